### hdl/bsfx_pkg.sv
// ----------------------------------------------------------------------------
// bsfx_pkg: shared types and constants of the byte stuffing framer
// Holds the queue entry layout, step bit positions and register indexes.
// ----------------------------------------------------------------------------
package bsfx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumSteps = 5;
  localparam int unsigned QDepth  = 2;

  localparam logic [ByteW-1:0] FlagReset   = 8'd36;
  localparam logic [ByteW-1:0] EscapeReset = 8'd47;

  // configuration register indexes
  localparam logic REG_FLAG   = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  // step bit positions, emitted in this order
  localparam int unsigned STEP_OPEN  = 0;
  localparam int unsigned STEP_ESC   = 1;
  localparam int unsigned STEP_DATA  = 2;
  localparam int unsigned STEP_CLOSE = 3;
  localparam int unsigned STEP_PAR   = 4;

  typedef logic [NumSteps-1:0] step_mask_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] flag_byte;
    logic [ByteW-1:0] escape_byte;
    step_mask_t       steps;
  } q_entry_t;

endpackage

### hdl/bsfx_if.sv
// ----------------------------------------------------------------------------
// bsfx_in_if / bsfx_out_if: valid-ready channels of the framer
// Input channel carries payload bytes, output channel carries framed bytes.
// ----------------------------------------------------------------------------
interface bsfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       packet_end;

  modport source (output valid, data_byte, byte_valid, packet_end, input ready);
  modport sink   (input valid, data_byte, byte_valid, packet_end, output ready);
endinterface

interface bsfx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_parity;
  logic       last_of_run;

  modport source (output valid, out_byte, is_parity, last_of_run, input ready);
  modport sink   (input valid, out_byte, is_parity, last_of_run, output ready);
endinterface

### hdl/byte_stuff_framer_xor_parity_top.sv
// ----------------------------------------------------------------------------
// byte_stuff_framer_xor_parity_top: byte stuffing framer with xor parity
// Frames payload bytes with flag and escape bytes and appends a parity byte.
// ----------------------------------------------------------------------------
// Each input item yields one to five output bytes: an opening flag at the
// start of a packet, an escape before a byte equal to the flag or escape
// register, the byte itself, and at packet end the closing flag followed by
// the xor parity of all framed bytes. The back end emits one output byte per
// cycle unless the output stalls, through its single output register; an
// item holds it until its results are out: a plain payload byte has one, an
// escaped byte two, an end item up to five. A two-entry queue lets the input
// keep taking items while earlier ones drain, each passing the queue and the
// output register. Items with neither a byte nor an end mark are taken and
// produce nothing. Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
module byte_stuff_framer_xor_parity_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  bsfx_in_if.sink     in_i,
  bsfx_out_if.source  out_o
);
  import bsfx_pkg::*;

  q_entry_t push_entry, head_entry;
  logic     q_push, q_full, q_pop, q_nonempty;

  bsfx_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .data_byte_i  (in_i.data_byte),
    .byte_valid_i (in_i.byte_valid),
    .packet_end_i (in_i.packet_end),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  bsfx_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .entry_i    (push_entry),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .head_o     (head_entry)
  );

  bsfx_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i  (q_nonempty),
    .head_i        (head_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .is_parity_o   (out_o.is_parity),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

### hdl/bsfx_front.sv
// ----------------------------------------------------------------------------
// bsfx_front: input side of the framer
// Accepts items, tracks the open frame and turns each item into a step list.
// ----------------------------------------------------------------------------
module bsfx_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [7:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    byte_valid_i,
  input  logic                    packet_end_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output bsfx_pkg::q_entry_t      q_entry_o
);
  import bsfx_pkg::*;

  logic [ByteW-1:0] flag_q, escape_q;
  logic             in_frame_q, in_frame_d;
  logic             accept;
  logic             needs_esc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // idle items are taken and dropped
  assign q_push_o   = accept && (byte_valid_i || packet_end_i);

  assign needs_esc = byte_valid_i && ((data_byte_i == flag_q) || (data_byte_i == escape_q));

  always_comb begin
    q_entry_o.data_byte           = data_byte_i;
    q_entry_o.flag_byte           = flag_q;
    q_entry_o.escape_byte         = escape_q;
    q_entry_o.steps               = '0;
    q_entry_o.steps[STEP_OPEN]    = !in_frame_q;
    q_entry_o.steps[STEP_ESC]     = needs_esc;
    q_entry_o.steps[STEP_DATA]    = byte_valid_i;
    q_entry_o.steps[STEP_CLOSE]   = packet_end_i;
    q_entry_o.steps[STEP_PAR]     = packet_end_i;
  end

  always_comb begin
    in_frame_d = in_frame_q;
    if (q_push_o) begin
      in_frame_d = !packet_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= FlagReset;
      escape_q   <= EscapeReset;
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FLAG:   flag_q   <= cfg_wdata_i;
          REG_ESCAPE: escape_q <= cfg_wdata_i;
          default:    ;
        endcase
      end
    end
  end

endmodule

### hdl/bsfx_queue.sv
// ----------------------------------------------------------------------------
// bsfx_queue: short step-list queue between front and back
// Register-based fifo, simultaneous push and pop allowed.
// ----------------------------------------------------------------------------
module bsfx_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bsfx_pkg::q_entry_t  entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                nonempty_o,
  output bsfx_pkg::q_entry_t  head_o
);
  import bsfx_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  q_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule

### hdl/bsfx_back.sv
// ----------------------------------------------------------------------------
// bsfx_back: output side of the framer
// Walks the head entry's steps, one byte a cycle unless stalled, keeps parity.
// ----------------------------------------------------------------------------
module bsfx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  bsfx_pkg::q_entry_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                is_parity_o,
  output logic                last_of_run_o
);
  import bsfx_pkg::*;

  step_mask_t       done_q, done_d;
  step_mask_t       remaining, sel, rem_after;
  logic [ByteW-1:0] parity_q, parity_d;
  logic [ByteW-1:0] byte_sel;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             is_parity_q, last_q;
  logic             can_load, fire;

  assign remaining = head_i.steps & ~done_q;

  // lowest pending step goes first
  always_comb begin
    sel = '0;
    priority if (remaining[STEP_OPEN])  sel[STEP_OPEN]  = 1'b1;
    else if (remaining[STEP_ESC])       sel[STEP_ESC]   = 1'b1;
    else if (remaining[STEP_DATA])      sel[STEP_DATA]  = 1'b1;
    else if (remaining[STEP_CLOSE])     sel[STEP_CLOSE] = 1'b1;
    else if (remaining[STEP_PAR])       sel[STEP_PAR]   = 1'b1;
    else                                sel             = '0;
  end

  assign rem_after = remaining & ~sel;

  always_comb begin
    byte_sel = head_i.flag_byte;
    if (sel[STEP_ESC]) begin
      byte_sel = head_i.escape_byte;
    end else if (sel[STEP_DATA]) begin
      byte_sel = head_i.data_byte;
    end else if (sel[STEP_PAR]) begin
      byte_sel = parity_q;
    end
  end

  assign can_load = !out_valid_q || out_ready_i;
  assign fire     = head_valid_i && can_load;
  assign pop_o    = fire && (rem_after == '0);

  always_comb begin
    done_d      = done_q;
    parity_d    = parity_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      done_d      = (rem_after == '0) ? '0 : (done_q | sel);
      if (sel[STEP_PAR]) begin
        parity_d = '0;
      end else begin
        parity_d = parity_q ^ byte_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q  <= byte_sel;
      is_parity_q <= sel[STEP_PAR];
      last_q      <= (rem_after == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      parity_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign is_parity_o   = is_parity_q;
  assign last_of_run_o = last_q;

endmodule

### hdl/bsfx_checker.sv
// ----------------------------------------------------------------------------
// bsfx_checker: port-level checks of the framer
// Watches the handshakes and result flags, bound to the top level.
// ----------------------------------------------------------------------------
module bsfx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       is_parity_i,
  input logic       last_of_run_i
);

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(is_parity_i) && $stable(last_of_run_i))
    else $error("output item changed while stalled");

  // parity byte always closes the run of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_parity_i |-> last_of_run_i)
    else $error("parity byte not marked last of run");

  // input only backs up when queued work is showing at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no output pending");

  // a stalled input item is still offered after the stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i)
    else $error("input item withdrawn while stalled");

endmodule

bind byte_stuff_framer_xor_parity_top bsfx_checker u_bsfx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .is_parity_i   (out_o.is_parity),
  .last_of_run_i (out_o.last_of_run)
);
